[rtl/mst_pkg.sv]
// Shared widths and defaults for the two-array merge unit.
// No dependencies; used by the interfaces, the sequencer and the top level.
package mst_pkg;

    localparam int VALUE_W      = 32;
    localparam int SLOT_W       = 6;
    localparam int CAPACITY_DEF = 32;

endpackage

[rtl/mst_in_if.sv]
// Load channel of the merge unit: one element per beat with its tags.
// Depends on mst_pkg for the value width.
interface mst_in_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [mst_pkg::VALUE_W-1:0]   item_value;
    logic                                 from_second;
    logic                                 last_item;

    modport source (output valid, output item_value, output from_second,
                    output last_item, input ready);
    modport sink   (input valid, input item_value, input from_second,
                    input last_item, output ready);
endinterface

[rtl/mst_out_if.sv]
// Result channel of the merge unit: one sorted value per beat with its destination.
// Depends on mst_pkg for the value and slot widths.
interface mst_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [mst_pkg::VALUE_W-1:0]   sorted_value;
    logic                                 to_second;
    logic        [mst_pkg::SLOT_W-1:0]    slot;
    logic                                 final_result;
    logic                                 overflowed;

    modport source (output valid, output sorted_value, output to_second,
                    output slot, output final_result, output overflowed,
                    input ready);
    modport sink   (input valid, input sorted_value, input to_second,
                    input slot, input final_result, input overflowed,
                    output ready);
endinterface

[rtl/mst_ram.sv]
// Generic simple dual-port RAM: one write and one registered read per cycle.
// No dependencies.
module mst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/mst_ctrl.sv]
// Sequencer of the merge unit: insertion sort on load through one compare unit,
// then ordered readout. Depends on mst_pkg, mst_in_if, mst_out_if; drives mst_ram.
module mst_ctrl #(
    parameter int CAPACITY = mst_pkg::CAPACITY_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    mst_in_if.sink                         i_in,
    mst_out_if.source                      o_out,
    output logic                           o_we,
    output logic [$clog2(CAPACITY)-1:0]    o_waddr,
    output logic [mst_pkg::VALUE_W-1:0]    o_wdata,
    output logic [$clog2(CAPACITY)-1:0]    o_raddr,
    input  logic [mst_pkg::VALUE_W-1:0]    i_rdata
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_INS_RD   = 3'd1;
    localparam logic [2:0] S_INS_CMP  = 3'd2;
    localparam logic [2:0] S_EMIT_RD  = 3'd3;
    localparam logic [2:0] S_EMIT_DAT = 3'd4;
    localparam logic [2:0] S_EMIT_OUT = 3'd5;

    logic [2:0]                  r_state, n_state;
    logic [CW-1:0]               r_cnt, n_cnt;
    logic [CW-1:0]               r_first, n_first;
    logic                        r_drop, n_drop;
    logic                        r_last, n_last;
    logic [CW-1:0]               r_j, n_j;
    logic [CW-1:0]               r_idx, n_idx;
    logic [mst_pkg::VALUE_W-1:0] r_val, n_val;
    logic                        r_ovalid, n_ovalid;
    logic [mst_pkg::VALUE_W-1:0] r_oval, n_oval;
    logic                        r_osec, n_osec;
    logic [mst_pkg::SLOT_W-1:0]  r_oslot, n_oslot;
    logic                        r_ofin, n_ofin;
    logic                        r_oovf, n_oovf;

    logic [CW-1:0] w_jm1;
    logic [CW-1:0] w_idx1;
    logic [CW-1:0] w_slot;
    logic          w_gt;
    logic          w_sec;
    logic          w_acc;

    assign w_jm1  = r_j - 1'b1;
    assign w_idx1 = r_idx + 1'b1;
    assign w_gt   = $signed(i_rdata) > $signed(r_val);
    assign w_sec  = r_idx >= r_first;
    assign w_slot = w_sec ? (r_idx - r_first) : r_idx;
    assign w_acc  = i_in.valid && (r_state == S_IDLE);

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_first  = r_first;
        n_drop   = r_drop;
        n_last   = r_last;
        n_j      = r_j;
        n_idx    = r_idx;
        n_val    = r_val;
        n_ovalid = r_ovalid;
        n_oval   = r_oval;
        n_osec   = r_osec;
        n_oslot  = r_oslot;
        n_ofin   = r_ofin;
        n_oovf   = r_oovf;
        o_we     = 1'b0;
        o_waddr  = r_j[AW-1:0];
        o_wdata  = r_val;
        o_raddr  = w_jm1[AW-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    n_last = i_in.last_item;
                    n_idx  = '0;
                    if (r_cnt < CW'(CAPACITY)) begin
                        n_val   = i_in.item_value;
                        n_j     = r_cnt;
                        n_cnt   = r_cnt + 1'b1;
                        n_first = r_first + CW'(!i_in.from_second);
                        n_state = S_INS_RD;
                    end else begin
                        // store full: drop the beat, still close the load on last
                        n_drop  = 1'b1;
                        n_state = i_in.last_item ? S_EMIT_RD : S_IDLE;
                    end
                end
            end
            S_INS_RD: begin
                if (r_j == '0) begin
                    o_we    = 1'b1;
                    n_state = r_last ? S_EMIT_RD : S_IDLE;
                end else begin
                    n_state = S_INS_CMP;
                end
            end
            S_INS_CMP: begin
                o_we = 1'b1;
                if (w_gt) begin
                    // shift the larger neighbor up one slot and keep walking down
                    o_wdata = i_rdata;
                    n_j     = w_jm1;
                    n_state = S_INS_RD;
                end else begin
                    n_state = r_last ? S_EMIT_RD : S_IDLE;
                end
            end
            S_EMIT_RD: begin
                o_raddr = r_idx[AW-1:0];
                n_state = S_EMIT_DAT;
            end
            S_EMIT_DAT: begin
                n_ovalid = 1'b1;
                n_oval   = i_rdata;
                n_osec   = w_sec;
                n_oslot  = mst_pkg::SLOT_W'(w_slot);
                n_ofin   = (w_idx1 == r_cnt);
                n_oovf   = r_drop;
                n_state  = S_EMIT_OUT;
            end
            S_EMIT_OUT: begin
                if (o_out.ready) begin
                    n_ovalid = 1'b0;
                    if (w_idx1 == r_cnt) begin
                        n_cnt   = '0;
                        n_first = '0;
                        n_drop  = 1'b0;
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = w_idx1;
                        n_state = S_EMIT_RD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_first  <= '0;
            r_drop   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_first  <= n_first;
            r_drop   <= n_drop;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_last  <= n_last;
        r_j     <= n_j;
        r_idx   <= n_idx;
        r_val   <= n_val;
        r_oval  <= n_oval;
        r_osec  <= n_osec;
        r_oslot <= n_oslot;
        r_ofin  <= n_ofin;
        r_oovf  <= n_oovf;
    end

    assign i_in.ready         = (r_state == S_IDLE);
    assign o_out.valid        = r_ovalid;
    assign o_out.sorted_value = r_oval;
    assign o_out.to_second    = r_osec;
    assign o_out.slot         = r_oslot;
    assign o_out.final_result = r_ofin;
    assign o_out.overflowed   = r_oovf;

endmodule

[rtl/merge_two_sorted_arrays_unit.sv]
// Two-array merge unit. Elements of both arrays are loaded one beat at a time and
// kept sorted by insertion into a single RAM: a loaded beat walks down from the top
// of the store past every stored value larger than it, each step being one RAM read
// and one compare before the shift write; a dropped beat is not stored. On the beat
// marked last, every stored value is sent out in ascending signed order, each value
// read, captured and handed over (waiting on ready) before the next one is read; the
// first values go to the first array, the rest to the second. The load port is not
// ready during insertion or readout. Beats beyond CAPACITY are dropped and reported
// on every result of that load.
// Depends on mst_pkg, mst_in_if, mst_out_if, mst_ram and mst_ctrl.
module merge_two_sorted_arrays_unit #(
    parameter int CAPACITY = mst_pkg::CAPACITY_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mst_in_if.sink     i_in,
    mst_out_if.source  o_out
);

    localparam int AW = $clog2(CAPACITY);

    logic                        w_we;
    logic [AW-1:0]               w_waddr;
    logic [mst_pkg::VALUE_W-1:0] w_wdata;
    logic [AW-1:0]               w_raddr;
    logic [mst_pkg::VALUE_W-1:0] w_rdata;

    mst_ram #(
        .WIDTH (mst_pkg::VALUE_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    mst_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_out   (o_out),
        .o_we    (w_we),
        .o_waddr (w_waddr),
        .o_wdata (w_wdata),
        .o_raddr (w_raddr),
        .i_rdata (w_rdata)
    );

endmodule
